// ===== rtl/char_lcd_command_generator_core_assert.svh =====
// Assertion macros for the character-LCD command generator checker.
// Included by the checker file; depends on nothing else.
`ifndef CHAR_LCD_COMMAND_GENERATOR_CORE_ASSERT_SVH
`define CHAR_LCD_COMMAND_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication under reset.
`define CLCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clcd checker: same-cycle property failed");

// Next-cycle implication under reset.
`define CLCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clcd checker: next-cycle property failed");

`endif

// ===== rtl/clcd_pkg.sv =====
// Shared types and constants for the character-LCD command generator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package clcd_pkg;

    typedef enum logic [3:0] {
        ACT_CHAR     = 4'd0,
        ACT_DECIMAL  = 4'd1,
        ACT_CURSOR   = 4'd2,
        ACT_CLEAR    = 4'd3,
        ACT_DISPLAY  = 4'd4,
        ACT_CUR_EN   = 4'd5,
        ACT_BLINK    = 4'd6,
        ACT_ENTRY    = 4'd7,
        ACT_SHIFT    = 4'd8,
        ACT_POWER_ON = 4'd9,
        ACT_INIT     = 4'd10
    } t_action;

    typedef enum logic [1:0] {
        JOB_SINGLE  = 2'd0,
        JOB_DECIMAL = 2'd1,
        JOB_INIT    = 2'd2
    } t_job_kind;

    typedef struct packed {
        logic [3:0] action;
        logic [7:0] value;
        logic [5:0] column;
        logic       row;
        logic       enable;
        logic       direction;
        logic       shift_on;
    } t_in_item;

    typedef struct packed {
        logic       reg_select;
        logic [7:0] bus_byte;
        logic       poll_busy;
        logic       last;
    } t_out_item;

    typedef struct packed {
        t_job_kind       kind;
        logic            reg_select;
        logic            poll_busy;
        logic [2:0][7:0] data_bytes;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    localparam logic [7:0] CMD_SET_ADDR    = 8'h80;
    localparam logic [7:0] ROW1_OFFSET     = 8'h40;
    localparam logic [7:0] CMD_CLEAR       = 8'h01;
    localparam logic [7:0] CMD_DISP_CTRL   = 8'h08;
    localparam logic [7:0] CMD_ENTRY       = 8'h04;
    localparam logic [7:0] CMD_SHIFT_RIGHT = 8'h1C;
    localparam logic [7:0] CMD_SHIFT_LEFT  = 8'h18;
    localparam logic [7:0] CMD_FUNC_SET    = 8'h38;
    localparam logic [7:0] CMD_DISP_ON     = 8'h0C;
    localparam logic [7:0] CMD_ENTRY_INC   = 8'h06;
    localparam logic [7:0] ASCII_ZERO      = 8'h30;
    localparam logic [7:0] ASCII_SPACE     = 8'h20;
    localparam logic [2:0] FLAGS_AFTER_INIT = 3'b100;
    localparam logic [2:0] INIT_LAST_STEP  = 3'd4;
    localparam logic [2:0] DEC_LAST_STEP   = 3'd2;

    // The five instruction writes of the full initialisation sequence.
    function automatic logic [7:0] init_byte(input logic [2:0] step);
        logic [7:0] b;
        begin
            case (step)
                3'd0:    b = CMD_FUNC_SET;
                3'd1:    b = CMD_DISP_ON;
                3'd2:    b = CMD_CLEAR;
                3'd3:    b = CMD_ENTRY_INC;
                3'd4:    b = CMD_SET_ADDR;
                default: b = CMD_SET_ADDR;
            endcase
            return b;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/clcd_front.sv =====
// Front end: accepts requests, keeps the display flags and turns each request with a used action code into a job.
// Depends on clcd_pkg.
`default_nettype none

module clcd_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  clcd_pkg::t_in_item   i_in_item,
    output logic                 o_in_ready,
    input  clcd_pkg::t_q_status  i_q_status,
    output logic                 o_push,
    output clcd_pkg::t_job       o_job
);
    import clcd_pkg::*;

    logic [2:0]  r_flags;
    logic [2:0]  n_flags;
    logic        accept;
    logic        keep;
    logic [1:0]  hundreds;
    logic [6:0]  rem;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [3:0]  units;
    logic [7:0]  tens_x10;
    logic [7:0]  h_x100;

    assign o_in_ready = !i_q_status.full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept && keep;

    // Decimal digits: compare for hundreds, reciprocal multiply for tens.
    always_comb begin
        hundreds  = (i_in_item.value >= 8'd200) ? 2'd2 :
                    (i_in_item.value >= 8'd100) ? 2'd1 : 2'd0;
        h_x100    = 8'(hundreds) * 8'd100;
        rem       = 7'(i_in_item.value - h_x100);
        tens_prod = 15'(rem) * 15'd205;
        tens      = tens_prod[14:11];
        tens_x10  = 8'(tens) * 8'd10;
        units     = 4'(8'(rem) - tens_x10);
    end

    always_comb begin
        n_flags           = r_flags;
        keep              = 1'b1;
        o_job.kind        = JOB_SINGLE;
        o_job.reg_select  = 1'b0;
        o_job.poll_busy   = 1'b1;
        o_job.data_bytes  = '0;
        unique case (i_in_item.action)
            ACT_CHAR: begin
                o_job.reg_select    = 1'b1;
                o_job.data_bytes[0] = i_in_item.value;
            end
            ACT_DECIMAL: begin
                o_job.kind          = JOB_DECIMAL;
                o_job.reg_select    = 1'b1;
                o_job.data_bytes[0] = (i_in_item.value >= 8'd100) ?
                                      ASCII_ZERO + 8'(hundreds) : ASCII_SPACE;
                o_job.data_bytes[1] = (i_in_item.value >= 8'd10) ?
                                      ASCII_ZERO + 8'(tens) : ASCII_SPACE;
                o_job.data_bytes[2] = ASCII_ZERO + 8'(units);
            end
            ACT_CURSOR: begin
                o_job.data_bytes[0] = CMD_SET_ADDR
                                      + (i_in_item.row ? ROW1_OFFSET : 8'h00)
                                      + 8'(i_in_item.column);
            end
            ACT_CLEAR: begin
                o_job.data_bytes[0] = CMD_CLEAR;
            end
            ACT_DISPLAY: begin
                n_flags[2]          = i_in_item.enable;
                o_job.data_bytes[0] = CMD_DISP_CTRL | 8'(n_flags);
            end
            ACT_CUR_EN: begin
                n_flags[1]          = i_in_item.enable;
                o_job.data_bytes[0] = CMD_DISP_CTRL | 8'(n_flags);
            end
            ACT_BLINK: begin
                n_flags[0]          = i_in_item.enable;
                o_job.data_bytes[0] = CMD_DISP_CTRL | 8'(n_flags);
            end
            ACT_ENTRY: begin
                o_job.data_bytes[0] = CMD_ENTRY
                                      | {6'd0, i_in_item.direction, i_in_item.shift_on};
            end
            ACT_SHIFT: begin
                o_job.data_bytes[0] = i_in_item.direction ? CMD_SHIFT_RIGHT : CMD_SHIFT_LEFT;
            end
            ACT_POWER_ON: begin
                o_job.poll_busy     = 1'b0;
                o_job.data_bytes[0] = CMD_FUNC_SET;
            end
            ACT_INIT: begin
                o_job.kind = JOB_INIT;
                n_flags    = FLAGS_AFTER_INIT;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (accept) begin
            r_flags <= n_flags;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/clcd_queue.sv =====
// Short job queue between the front end and the write sequencer.
// Depends on clcd_pkg.
`default_nettype none

module clcd_queue #(
    parameter int DEPTH = 2
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  clcd_pkg::t_job       i_job,
    input  wire                  i_pop,
    output clcd_pkg::t_job       o_job,
    output clcd_pkg::t_q_status  o_status
);
    import clcd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_job          = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/clcd_back.sv =====
// Write sequencer: expands each queued job into bus writes, one per cycle unless the output
// stalls, into a registered output stage. Depends on clcd_pkg.
`default_nettype none

module clcd_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  clcd_pkg::t_job       i_job,
    input  clcd_pkg::t_q_status  i_q_status,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output clcd_pkg::t_out_item  o_out_item
);
    import clcd_pkg::*;

    logic [2:0] r_step;
    logic       r_out_valid;
    t_out_item  r_out_item;
    t_out_item  n_out_item;
    logic       load;
    logic       step_last;

    assign load = !i_q_status.empty && (!r_out_valid || i_out_ready);
    assign o_pop = load && step_last;

    always_comb begin
        step_last             = 1'b1;
        n_out_item.reg_select = i_job.reg_select;
        n_out_item.poll_busy  = i_job.poll_busy;
        n_out_item.bus_byte   = i_job.data_bytes[0];
        unique case (i_job.kind)
            JOB_SINGLE: begin
                step_last = 1'b1;
            end
            JOB_DECIMAL: begin
                step_last = (r_step == DEC_LAST_STEP);
                case (r_step)
                    3'd0:    n_out_item.bus_byte = i_job.data_bytes[0];
                    3'd1:    n_out_item.bus_byte = i_job.data_bytes[1];
                    default: n_out_item.bus_byte = i_job.data_bytes[2];
                endcase
            end
            JOB_INIT: begin
                step_last           = (r_step == INIT_LAST_STEP);
                n_out_item.bus_byte = init_byte(r_step);
            end
            default: begin
                step_last = 1'b1;
            end
        endcase
        n_out_item.last = step_last;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_item <= n_out_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_step      <= step_last ? 3'd0 : r_step + 3'd1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ===== rtl/char_lcd_command_generator_core.sv =====
// Top level of the character-LCD command generator: front end, job queue and write sequencer.
// Depends on clcd_pkg, clcd_front, clcd_queue and clcd_back.
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+-----------------------------
//  request | in        | i_in_valid / o_in_ready    | i_in_item  (clcd_pkg::t_in_item)
//  write   | out       | o_out_valid / i_out_ready  | o_out_item (clcd_pkg::t_out_item)
//
// The sequencer issues one bus write per cycle unless the output stalls: a request makes one
// write, a decimal number three and the full initialisation five, set by its step counter.
// Reset is synchronous and active low; it clears the display flags, the queue and the
// output stage. The front end accepts a request whenever the job queue has room, so requests
// keep arriving while a stalled write waits in the output register.
// Requests with an unused action code are accepted and produce no writes.
`default_nettype none

module char_lcd_command_generator_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  clcd_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output clcd_pkg::t_out_item  o_out_item
);
    import clcd_pkg::*;

    // Jobs travel from the front end through the queue to the sequencer.
    t_job      push_job;
    t_job      head_job;
    t_q_status q_status;
    logic      push;
    logic      pop;

    // The front end classifies each transaction and tracks the display/cursor/blink flags.
    clcd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_ready (o_in_ready),
        .i_q_status (q_status),
        .o_push     (push),
        .o_job      (push_job)
    );

    // The queue lets the front end and the sequencer stall independently.
    clcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    // The sequencer expands the head job into write transactions.
    clcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

// ===== rtl/clcd_checker.sv =====
// Port-level checks for the character-LCD command generator, bound to the top level.
// Depends on clcd_pkg and char_lcd_command_generator_core_assert.svh.
`default_nettype none

`include "char_lcd_command_generator_core_assert.svh"

module clcd_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_ready,
    input clcd_pkg::t_in_item  i_in_item,
    input wire                 o_out_valid,
    input wire                 i_out_ready,
    input clcd_pkg::t_out_item o_out_item
);
    import clcd_pkg::*;

    // A waiting request must hold.
    `CLCD_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && !o_in_ready, i_in_valid && $stable(i_in_item))

    // A stalled write must hold.
    `CLCD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item))

    // Data writes always wait for the busy flag.
    `CLCD_ASSERT_NOW(a_data_polls, i_clk, i_rst_n, o_out_valid && o_out_item.reg_select, o_out_item.poll_busy)

    // Only the power-on function set skips the busy poll, and it is a one-write request.
    `CLCD_ASSERT_NOW(a_no_poll_power_on, i_clk, i_rst_n, o_out_valid && !o_out_item.poll_busy, !o_out_item.reg_select && o_out_item.bus_byte == CMD_FUNC_SET && o_out_item.last)

    // No write is offered straight after reset.
    `CLCD_ASSERT_NOW(a_quiet_after_reset, i_clk, i_rst_n, $past(!i_rst_n), !o_out_valid)

endmodule

bind char_lcd_command_generator_core clcd_checker u_checker (.*);

`default_nettype wire
